// ===== src/rdc_pkg.sv =====
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared constants, types and controller/datapath bundles for the radix
// digit converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rdc_pkg;

  localparam int VALUE_BITS = 31;
  localparam int MAX_BASE   = 256;
  localparam int MAX_DIGITS = 32;

  localparam int RADIX_W = 9;
  localparam int DIGIT_W = 8;
  localparam int REM_W   = RADIX_W + 1;
  localparam int ADDR_W  = $clog2(MAX_DIGITS);
  localparam int CNT_W   = $clog2(MAX_DIGITS + 1);
  localparam int BIT_W   = $clog2(VALUE_BITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_STORE,
    ST_READ,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic store;
    logic emit;
    logic emit_err;
  } cmd_t;

  typedef struct packed {
    logic radix_bad;
    logic bit_done;
    logic quot_zero;
    logic count_last;
    logic count_one;
  } status_t;

endpackage

`default_nettype wire

// ===== src/rdc_ram.sv =====
// ----------------------------------------------------------------------------
// rdc_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

// ===== src/rdc_ctrl.sv =====
// ----------------------------------------------------------------------------
// rdc_ctrl
// Controller: sequences division steps, digit stores and digit emission.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire rdc_pkg::status_t status_i,
  output rdc_pkg::cmd_t         cmd_o,
  output logic                  busy_o
);
  import rdc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          if (status_i.radix_bad) begin
            cmd_o.emit_err = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.bit_done) begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd_o.store = 1'b1;
        if (status_i.quot_zero || status_i.count_last) begin
          state_d = ST_READ;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_READ: begin
        // ram read of the next digit is in flight
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d    = status_i.count_one ? ST_IDLE : ST_READ;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/rdc_datapath.sv =====
// ----------------------------------------------------------------------------
// rdc_datapath
// Bit-serial restoring divider, digit store and registered result outputs.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic [rdc_pkg::VALUE_BITS-1:0]      value_i,
  input  wire logic [rdc_pkg::RADIX_W-1:0]         radix_i,
  input  wire rdc_pkg::cmd_t                       cmd_i,
  output rdc_pkg::status_t                         status_o,
  output logic                                     strobe_o,
  output logic      [rdc_pkg::DIGIT_W-1:0]         digit_o,
  output logic                                     last_o,
  output logic                                     error_o
);
  import rdc_pkg::*;

  logic [VALUE_BITS-1:0] quot_q, quot_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [RADIX_W-1:0]    base_q, base_d;
  logic [BIT_W-1:0]      bit_cnt_q, bit_cnt_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  strobe_q, strobe_d;
  logic [DIGIT_W-1:0]    digit_q, digit_d;
  logic                  last_q, last_d;
  logic                  error_q, error_d;

  logic [REM_W-1:0]      trial;
  logic                  trial_ge;
  logic [CNT_W-1:0]      count_m1;
  logic [ADDR_W-1:0]     ram_addr;
  logic [DIGIT_W-1:0]    ram_rdata;

  assign trial    = {rem_q[REM_W-2:0], quot_q[VALUE_BITS-1]};
  assign trial_ge = trial >= {1'b0, base_q};
  assign count_m1 = count_q - CNT_W'(1);
  assign ram_addr = cmd_i.store ? count_q[ADDR_W-1:0] : count_m1[ADDR_W-1:0];

  assign status_o.radix_bad  = (radix_i < RADIX_W'(2)) ||
                               (32'(radix_i) > 32'(MAX_BASE));
  assign status_o.bit_done   = bit_cnt_q == BIT_W'(VALUE_BITS - 1);
  assign status_o.quot_zero  = quot_q == '0;
  assign status_o.count_last = count_q == CNT_W'(MAX_DIGITS - 1);
  assign status_o.count_one  = count_q == CNT_W'(1);

  rdc_ram #(
    .Width (DIGIT_W),
    .Depth (MAX_DIGITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store),
    .addr_i  (ram_addr),
    .wdata_i (rem_q[DIGIT_W-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    quot_d    = quot_q;
    rem_d     = rem_q;
    base_d    = base_q;
    bit_cnt_d = bit_cnt_q;
    count_d   = count_q;
    strobe_d  = cmd_i.emit || cmd_i.emit_err;
    digit_d   = digit_q;
    last_d    = last_q;
    error_d   = error_q;

    if (cmd_i.load) begin
      quot_d    = value_i;
      rem_d     = '0;
      base_d    = radix_i;
      bit_cnt_d = '0;
      count_d   = '0;
    end

    if (cmd_i.div_step) begin
      rem_d     = trial_ge ? trial - {1'b0, base_q} : trial;
      quot_d    = {quot_q[VALUE_BITS-2:0], trial_ge};
      bit_cnt_d = status_o.bit_done ? '0 : bit_cnt_q + BIT_W'(1);
    end

    if (cmd_i.store) begin
      // remainder now sits in the ram, start the next division clean
      rem_d   = '0;
      count_d = count_q + CNT_W'(1);
    end

    if (cmd_i.emit) begin
      digit_d = ram_rdata;
      last_d  = status_o.count_one;
      error_d = 1'b0;
      count_d = count_m1;
    end

    if (cmd_i.emit_err) begin
      digit_d = '0;
      last_d  = 1'b1;
      error_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_cnt_q <= '0;
      count_q   <= '0;
      quot_q    <= '0;
      strobe_q  <= 1'b0;
    end else begin
      bit_cnt_q <= bit_cnt_d;
      count_q   <= count_d;
      quot_q    <= quot_d;
      strobe_q  <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    base_q  <= base_d;
    digit_q <= digit_d;
    last_q  <= last_d;
    error_q <= error_d;
  end

  assign strobe_o = strobe_q;
  assign digit_o  = digit_q;
  assign last_o   = last_q;
  assign error_o  = error_q;

endmodule

`default_nettype wire

// ===== src/radix_digit_converter_core.sv =====
// ----------------------------------------------------------------------------
// radix_digit_converter_core
// Converts a value to digits of a chosen base, most significant digit first.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low. Each digit is a
// restoring division by the base, one quotient bit per cycle, so a digit costs
// 31 division steps and one store into the digit ram, and emission then
// reads each digit through the registered ram read. busy_o stays high for
// the whole conversion of up to 31 digits. A base below 2 or above 256 gives a
// single digit 0 with error_o and last_o set, in the cycle after the item, and
// busy_o stays low. Digits come out on strobe_o, one cycle each, and the
// receiver must take every one as it appears: there is no back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_digit_converter_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [rdc_pkg::VALUE_BITS-1:0] value_i,
  input  wire logic [rdc_pkg::RADIX_W-1:0]    radix_i,
  output logic                                busy_o,
  output logic                                strobe_o,
  output logic      [rdc_pkg::DIGIT_W-1:0]    digit_o,
  output logic                                last_o,
  output logic                                error_o
);
  import rdc_pkg::*;

  cmd_t    cmd;
  status_t status;

  rdc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  rdc_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .value_i  (value_i),
    .radix_i  (radix_i),
    .cmd_i    (cmd),
    .status_o (status),
    .strobe_o (strobe_o),
    .digit_o  (digit_o),
    .last_o   (last_o),
    .error_o  (error_o)
  );

endmodule

`default_nettype wire

// ===== src/rdc_checker.sv =====
// ----------------------------------------------------------------------------
// rdc_checker
// Port-level checks on item acceptance and digit sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [rdc_pkg::VALUE_BITS-1:0] value_i,
  input  wire logic [rdc_pkg::RADIX_W-1:0]    radix_i,
  input  wire logic                           busy_o,
  input  wire logic                           strobe_o,
  input  wire logic [rdc_pkg::DIGIT_W-1:0]    digit_o,
  input  wire logic                           last_o,
  input  wire logic                           error_o
);
  import rdc_pkg::*;

  logic accept;
  logic radix_bad;

  assign accept    = start_i && !busy_o;
  assign radix_bad = (radix_i < RADIX_W'(2)) || (32'(radix_i) > 32'(MAX_BASE));

  // an error result is a lone zero digit
  a_error_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && error_o |-> last_o && (digit_o == '0))
    else $error("error item is not a single zero digit");

  // bad base answers at once
  a_bad_radix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && radix_bad |=> strobe_o && error_o && !busy_o)
    else $error("bad radix not flagged in the next cycle");

  // good base starts a conversion
  a_good_radix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !radix_bad && (value_i == value_i) |=> busy_o && !strobe_o)
    else $error("conversion did not start");

  // more digits follow a non-final one
  a_more_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |-> busy_o && !error_o)
    else $error("non-final digit while idle");

  a_digit_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |=> !strobe_o)
    else $error("digits not spaced by a read cycle");

endmodule

bind radix_digit_converter_core rdc_checker u_rdc_checker (.*);

`default_nettype wire
